FILE: design/wvac_pkg.sv
package wvac_pkg;

    // default encoder resolution
    localparam int ENCODER_BITS_DEF = 12;

    // fixed field widths
    localparam int ANGLE_W   = 9;
    localparam int SAIL_W    = 8;
    localparam int HEADING_W = 9;
    localparam int CFG_IDX_W = 2;

    // quotient of one segment never exceeds 90, so seven bits cover it
    localparam int Q_W   = 7;
    localparam int CNT_W = 3;
    // signed angle before the 360 wrap spans -90..525
    localparam int ANG_W = 11;
    // heading + 360 - stored spans 0..871
    localparam int TURN_W = 10;

    localparam int QUARTER_TURN       = 90;
    localparam int HALF_TURN          = 180;
    localparam int THREE_QUARTER_TURN = 270;
    localparam int FULL_TURN          = 360;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_QUARTER = 2'd3;

    typedef enum logic [3:0] {
        U_LATCH,
        U_SUM,
        U_WRAPX,
        U_SEG,
        U_MUL,
        U_DIV,
        U_ADD,
        U_WRAPA,
        U_TRUE,
        U_NOP,
        U_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_QUERY,
        C_SPAN_ZERO,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic no_input;
        logic query;
        logic span_zero;
        logic div_more;
        logic out_busy;
    } stat_t;

    // program step addresses
    localparam logic [PC_W-1:0] S_FETCH = 4'd0;
    localparam logic [PC_W-1:0] S_SUM   = 4'd1;
    localparam logic [PC_W-1:0] S_WRAPX = 4'd2;
    localparam logic [PC_W-1:0] S_SEG   = 4'd3;
    localparam logic [PC_W-1:0] S_MUL   = 4'd4;
    localparam logic [PC_W-1:0] S_DIV   = 4'd5;
    localparam logic [PC_W-1:0] S_ADD   = 4'd6;
    localparam logic [PC_W-1:0] S_WRAPA = 4'd7;
    localparam logic [PC_W-1:0] S_TRUE  = 4'd8;
    localparam logic [PC_W-1:0] S_WAIT  = 4'd9;
    localparam logic [PC_W-1:0] S_EMIT  = 4'd10;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            S_FETCH: w = '{U_LATCH, C_NO_INPUT,  S_FETCH};
            S_SUM:   w = '{U_SUM,   C_QUERY,     S_TRUE};
            S_WRAPX: w = '{U_WRAPX, C_NONE,      S_FETCH};
            S_SEG:   w = '{U_SEG,   C_NONE,      S_FETCH};
            S_MUL:   w = '{U_MUL,   C_SPAN_ZERO, S_ADD};
            S_DIV:   w = '{U_DIV,   C_DIV_MORE,  S_DIV};
            S_ADD:   w = '{U_ADD,   C_NONE,      S_FETCH};
            S_WRAPA: w = '{U_WRAPA, C_NONE,      S_FETCH};
            S_TRUE:  w = '{U_TRUE,  C_NONE,      S_FETCH};
            S_WAIT:  w = '{U_NOP,   C_OUT_BUSY,  S_WAIT};
            S_EMIT:  w = '{U_EMIT,  C_ALWAYS,    S_FETCH};
            default: w = '{U_NOP,   C_ALWAYS,    S_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: design/wvac_useq.sv
module wvac_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  wvac_pkg::stat_t     stat,
    output wvac_pkg::uop_t      uop
);

    logic [wvac_pkg::PC_W-1:0] pc_reg;
    logic [wvac_pkg::PC_W-1:0] pc_next;
    wvac_pkg::ucode_t          uc;
    logic                      take;

    always_comb
    begin
        uc = wvac_pkg::ucode_rom(pc_reg);
    end

    always_comb
    begin
        unique case (uc.cond)
            wvac_pkg::C_NONE:      take = 1'b0;
            wvac_pkg::C_ALWAYS:    take = 1'b1;
            wvac_pkg::C_NO_INPUT:  take = stat.no_input;
            wvac_pkg::C_QUERY:     take = stat.query;
            wvac_pkg::C_SPAN_ZERO: take = stat.span_zero;
            wvac_pkg::C_DIV_MORE:  take = stat.div_more;
            wvac_pkg::C_OUT_BUSY:  take = stat.out_busy;
            default:               take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = take ? uc.target : pc_reg + wvac_pkg::PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= wvac_pkg::S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign uop = uc.uop;

endmodule

FILE: design/wvac_dpath.sv
module wvac_dpath #(
    parameter int ENCODER_BITS = wvac_pkg::ENCODER_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wvac_pkg::uop_t                        uop,
    output wvac_pkg::stat_t                       stat,
    input  logic                                  in_valid,
    input  logic                                  operation,
    input  logic [ENCODER_BITS-1:0]               raw_angle,
    input  logic [wvac_pkg::SAIL_W-1:0]           sail_position,
    input  logic [wvac_pkg::HEADING_W-1:0]        heading,
    input  logic signed [ENCODER_BITS:0]          encoder_offset,
    input  logic [ENCODER_BITS-1:0]               quarter_point,
    input  logic [ENCODER_BITS-1:0]               half_point,
    input  logic [ENCODER_BITS-1:0]               three_quarter_point,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [wvac_pkg::ANGLE_W-1:0]          apparent_angle,
    output logic [wvac_pkg::ANGLE_W-1:0]          true_angle
);

    localparam int EB    = ENCODER_BITS;
    localparam int SUM_W = EB + 2;
    localparam int QW    = wvac_pkg::Q_W;
    localparam int NUM_W = EB + QW;
    localparam int CW    = wvac_pkg::CNT_W;
    localparam int AW    = wvac_pkg::ANGLE_W;
    localparam int GW    = wvac_pkg::ANG_W;
    localparam int TW    = wvac_pkg::TURN_W;
    localparam int SW    = wvac_pkg::SAIL_W;
    localparam int HW    = wvac_pkg::HEADING_W;

    localparam logic [EB-1:0]           ENC_MAX   = '1;
    localparam logic signed [SUM_W-1:0] ENC_MAX_S = $signed({2'b00, ENC_MAX});
    localparam logic signed [GW-1:0]    QUARTER_S = $signed(GW'(wvac_pkg::QUARTER_TURN));
    localparam logic signed [GW-1:0]    FULL_S    = $signed(GW'(wvac_pkg::FULL_TURN));
    localparam logic [TW-1:0]           FULL_T    = TW'(wvac_pkg::FULL_TURN);
    localparam logic [TW-1:0]           HALF_T    = TW'(wvac_pkg::HALF_TURN);

    // latched transaction
    logic                      op_reg, op_next;
    logic [EB-1:0]             raw_reg, raw_next;
    logic [SW-1:0]             sail_reg, sail_next;
    logic [HW-1:0]             heading_reg, heading_next;
    // working registers
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [EB-1:0]             x_reg, x_next;
    logic [EB-1:0]             diff_reg, diff_next;
    logic [EB-1:0]             span_reg, span_next;
    logic                      spanz_reg, spanz_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          dvs_reg, dvs_next;
    logic [QW-1:0]             quo_reg, quo_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [GW-1:0]      ang_reg, ang_next;
    logic [AW-1:0]             w1_reg, w1_next;
    logic [AW-1:0]             app_reg, app_next;
    logic [AW-1:0]             true_reg, true_next;
    // control state
    logic [AW-1:0]             stored_reg, stored_next;
    logic                      out_valid_reg, out_valid_next;

    // combinational helpers
    logic signed [SUM_W-1:0]   wrap_s;
    logic [EB-1:0]             seg_lo;
    logic [EB-1:0]             seg_hi;
    logic [AW-1:0]             seg_base;
    logic [TW-1:0]             w_sum;
    logic [TW-1:0]             w2_sum;

    always_comb
    begin
        // single wrap of the offset sum
        if (sum_reg > ENC_MAX_S)
        begin
            wrap_s = sum_reg - ENC_MAX_S;
        end
        else if (sum_reg < $signed(SUM_W'(0)))
        begin
            wrap_s = sum_reg + ENC_MAX_S;
        end
        else
        begin
            wrap_s = sum_reg;
        end

        // segments tested from the top breakpoint down
        if (x_reg >= three_quarter_point)
        begin
            seg_lo   = three_quarter_point;
            seg_hi   = ENC_MAX;
            seg_base = AW'(wvac_pkg::THREE_QUARTER_TURN);
        end
        else if (x_reg >= half_point)
        begin
            seg_lo   = half_point;
            seg_hi   = three_quarter_point;
            seg_base = AW'(wvac_pkg::HALF_TURN);
        end
        else if (x_reg >= quarter_point)
        begin
            seg_lo   = quarter_point;
            seg_hi   = half_point;
            seg_base = AW'(wvac_pkg::QUARTER_TURN);
        end
        else
        begin
            seg_lo   = '0;
            seg_hi   = quarter_point;
            seg_base = '0;
        end

        w_sum  = TW'(heading_reg) + FULL_T - TW'(stored_reg);
        w2_sum = TW'(w1_reg) + HALF_T;
    end

    always_comb
    begin
        op_next        = op_reg;
        raw_next       = raw_reg;
        sail_next      = sail_reg;
        heading_next   = heading_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        diff_next      = diff_reg;
        span_next      = span_reg;
        spanz_next     = spanz_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        ang_next       = ang_reg;
        w1_next        = w1_reg;
        app_next       = app_reg;
        true_next      = true_reg;
        stored_next    = stored_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (uop)
            wvac_pkg::U_LATCH:
            begin
                if (in_valid)
                begin
                    op_next      = operation;
                    raw_next     = raw_angle;
                    sail_next    = sail_position;
                    heading_next = heading;
                end
            end
            wvac_pkg::U_SUM:
            begin
                sum_next = $signed({2'b00, raw_reg})
                         + $signed({encoder_offset[EB], encoder_offset});
            end
            wvac_pkg::U_WRAPX:
            begin
                if (wrap_s < $signed(SUM_W'(0)))
                begin
                    x_next = '0;
                end
                else if (wrap_s > ENC_MAX_S)
                begin
                    x_next = ENC_MAX;
                end
                else
                begin
                    x_next = wrap_s[EB-1:0];
                end
            end
            wvac_pkg::U_SEG:
            begin
                diff_next  = x_reg - seg_lo;
                span_next  = seg_hi - seg_lo;
                spanz_next = (seg_hi <= seg_lo);
                base_next  = seg_base;
            end
            wvac_pkg::U_MUL:
            begin
                rem_next = NUM_W'(diff_reg) * NUM_W'(wvac_pkg::QUARTER_TURN);
                dvs_next = {1'b0, span_reg, {(QW-1){1'b0}}};
                quo_next = '0;
                cnt_next = CW'(QW - 1);
            end
            wvac_pkg::U_DIV:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
            end
            wvac_pkg::U_ADD:
            begin
                ang_next = $signed(GW'(base_reg)) + $signed(GW'(quo_reg))
                         + $signed(GW'(sail_reg)) - QUARTER_S;
            end
            wvac_pkg::U_WRAPA:
            begin
                if (ang_reg < $signed(GW'(0)))
                begin
                    stored_next = AW'(ang_reg + FULL_S);
                end
                else if (ang_reg > FULL_S)
                begin
                    stored_next = AW'(ang_reg - FULL_S);
                end
                else
                begin
                    stored_next = ang_reg[AW-1:0];
                end
            end
            wvac_pkg::U_TRUE:
            begin
                w1_next = (w_sum > FULL_T) ? AW'(w_sum - FULL_T) : w_sum[AW-1:0];
            end
            wvac_pkg::U_NOP:
            begin
            end
            wvac_pkg::U_EMIT:
            begin
                app_next       = stored_reg;
                true_next      = (w2_sum > FULL_T) ? AW'(w2_sum - FULL_T) : w2_sum[AW-1:0];
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            spanz_reg     <= 1'b0;
            op_reg        <= 1'b0;
        end
        else
        begin
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            spanz_reg     <= spanz_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        sail_reg    <= sail_next;
        heading_reg <= heading_next;
        sum_reg     <= sum_next;
        x_reg       <= x_next;
        diff_reg    <= diff_next;
        span_reg    <= span_next;
        base_reg    <= base_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quo_reg     <= quo_next;
        ang_reg     <= ang_next;
        w1_reg      <= w1_next;
        app_reg     <= app_next;
        true_reg    <= true_next;
    end

    always_comb
    begin
        stat.no_input  = !in_valid;
        stat.query     = op_reg;
        stat.span_zero = spanz_reg;
        stat.div_more  = (cnt_reg != '0);
        stat.out_busy  = out_valid_reg && out_stall;
    end

    assign out_valid      = out_valid_reg;
    assign apparent_angle = app_reg;
    assign true_angle     = true_reg;

    // stored angle stays within one turn
    a_stored_range: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= AW'(wvac_pkg::FULL_TURN))
        else $error("stored angle above 360");

    // a segment quotient never exceeds a quarter turn
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == wvac_pkg::U_ADD) |-> (quo_reg <= QW'(wvac_pkg::QUARTER_TURN)))
        else $error("segment quotient above 90");

    // a result is only loaded into an empty or draining output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == wvac_pkg::U_EMIT) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

    // an emitted transaction shows the current stored angle
    a_emit_value: assert property (@(posedge clk) disable iff (!rst_n)
        (uop == wvac_pkg::U_EMIT) |=> (out_valid_reg && app_reg == stored_reg
            && true_reg <= AW'(wvac_pkg::FULL_TURN)))
        else $error("emitted result mismatch");

endmodule

FILE: design/wind_vane_angle_calibrator.sv
// Wind vane angle calibrator. Each input transaction yields exactly one result
// transaction carrying the stored apparent wind angle and the true wind angle.
// Operation 0 corrects the encoder reading by the signed offset, maps it through
// the three breakpoints onto four quadrants, adds the sail position less 90 and
// stores the wrapped angle; operation 1 reports using the stored angle as is.
// A small microcoded sequencer drives one shared datapath. In operation 0 the
// seven-step restoring divider of the segment interpolation is the longest
// part and is skipped when the selected segment has zero width; operation 1
// goes from the offset sum straight to the true angle. A new transaction is
// taken while the previous result still waits in the output register; the next
// result waits for that register to drain. Breakpoint and offset registers
// must be written only while the block is idle; the block does not enforce it.
module wind_vane_angle_calibrator #(
    parameter int ENCODER_BITS = wvac_pkg::ENCODER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wvac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ENCODER_BITS:0]               cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [ENCODER_BITS-1:0]             raw_angle,
    input  logic [wvac_pkg::SAIL_W-1:0]         sail_position,
    input  logic [wvac_pkg::HEADING_W-1:0]      heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wvac_pkg::ANGLE_W-1:0]        apparent_angle,
    output logic [wvac_pkg::ANGLE_W-1:0]        true_angle
);

    localparam int EB = ENCODER_BITS;
    localparam logic [EB-1:0] QUARTER_RST       = EB'(1) << (EB - 2);
    localparam logic [EB-1:0] HALF_RST          = EB'(1) << (EB - 1);
    localparam logic [EB-1:0] THREE_QUARTER_RST = QUARTER_RST | HALF_RST;

    logic signed [EB:0] offset_reg;
    logic [EB-1:0]      quarter_reg;
    logic [EB-1:0]      half_reg;
    logic [EB-1:0]      three_quarter_reg;

    wvac_pkg::uop_t     uop;
    wvac_pkg::stat_t    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg        <= '0;
            quarter_reg       <= QUARTER_RST;
            half_reg          <= HALF_RST;
            three_quarter_reg <= THREE_QUARTER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wvac_pkg::CFG_OFFSET:        offset_reg        <= $signed(cfg_data);
                wvac_pkg::CFG_QUARTER:       quarter_reg       <= cfg_data[EB-1:0];
                wvac_pkg::CFG_HALF:          half_reg          <= cfg_data[EB-1:0];
                wvac_pkg::CFG_THREE_QUARTER: three_quarter_reg <= cfg_data[EB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // inputs are taken only at the fetch step of the program
    assign in_stall = (uop != wvac_pkg::U_LATCH);

    wvac_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uop   (uop)
    );

    wvac_dpath #(
        .ENCODER_BITS (ENCODER_BITS)
    ) u_dpath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .uop                 (uop),
        .stat                (stat),
        .in_valid            (in_valid),
        .operation           (operation),
        .raw_angle           (raw_angle),
        .sail_position       (sail_position),
        .heading             (heading),
        .encoder_offset      (offset_reg),
        .quarter_point       (quarter_reg),
        .half_point          (half_reg),
        .three_quarter_point (three_quarter_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .apparent_angle      (apparent_angle),
        .true_angle          (true_angle)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int ENC_MAX     = (1 << wvac_pkg::ENCODER_BITS_DEF) - 1;
    localparam int EBITS       = wvac_pkg::ENCODER_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_PRINTED = 40;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [wvac_pkg::ANGLE_W-1:0] apparent_deg;
        logic [wvac_pkg::ANGLE_W-1:0] true_deg;
    } angle_pair_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [wvac_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [EBITS:0]                    cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic                              operation;
    logic [EBITS-1:0]                  raw_angle;
    logic [wvac_pkg::SAIL_W-1:0]       sail_position;
    logic [wvac_pkg::HEADING_W-1:0]    heading;
    logic                              out_valid;
    logic                              out_stall;
    logic [wvac_pkg::ANGLE_W-1:0]      apparent_angle;
    logic [wvac_pkg::ANGLE_W-1:0]      true_angle;

    // calibration and vane state as the block should hold them
    int model_offset;
    int model_quarter;
    int model_half;
    int model_three_quarter;
    int model_stored;

    angle_pair_t expected_angles[$];
    int          error_count;
    int          cycle_count = 0;
    bit          gaps_on;
    bit          stalls_on;

    wind_vane_angle_calibrator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .raw_angle      (raw_angle),
        .sail_position  (sail_position),
        .heading        (heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .apparent_angle (apparent_angle),
        .true_angle     (true_angle)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int interpolate(input int x, input int lo, input int hi, input int base);
        int span;
        span = hi - lo;
        if (span <= 0)
            return base;
        return (x - lo) * wvac_pkg::QUARTER_TURN / span + base;
    endfunction

    function automatic angle_pair_t predict_angles(input logic op,
                                                   input logic [EBITS-1:0] raw,
                                                   input logic [wvac_pkg::SAIL_W-1:0] sail,
                                                   input logic [wvac_pkg::HEADING_W-1:0] hdg);
        int          count;
        int          mapped;
        int          wind;
        int          turn;
        angle_pair_t res;
        if (op == OP_SAMPLE)
        begin
            // one wrap only, then clamp whatever is still out of range
            count = int'(raw) + model_offset;
            if (count > ENC_MAX)
                count -= ENC_MAX;
            else if (count < 0)
                count += ENC_MAX;
            if (count < 0)
                count = 0;
            if (count > ENC_MAX)
                count = ENC_MAX;
            // breakpoints checked from the top down
            if (count >= model_three_quarter)
                mapped = interpolate(count, model_three_quarter, ENC_MAX,
                                     wvac_pkg::THREE_QUARTER_TURN);
            else if (count >= model_half)
                mapped = interpolate(count, model_half, model_three_quarter,
                                     wvac_pkg::HALF_TURN);
            else if (count >= model_quarter)
                mapped = interpolate(count, model_quarter, model_half,
                                     wvac_pkg::QUARTER_TURN);
            else
                mapped = interpolate(count, 0, model_quarter, 0);
            wind = mapped + int'(sail) - wvac_pkg::QUARTER_TURN;
            if (wind < 0)
                wind += wvac_pkg::FULL_TURN;
            else if (wind > wvac_pkg::FULL_TURN)
                wind -= wvac_pkg::FULL_TURN;
            model_stored = wind;
        end
        turn = int'(hdg) + wvac_pkg::FULL_TURN - model_stored;
        if (turn < 0)
            turn += wvac_pkg::FULL_TURN;
        else if (turn > wvac_pkg::FULL_TURN)
            turn -= wvac_pkg::FULL_TURN;
        turn += wvac_pkg::HALF_TURN;
        if (turn > wvac_pkg::FULL_TURN)
            turn -= wvac_pkg::FULL_TURN;
        res.apparent_deg = wvac_pkg::ANGLE_W'(model_stored);
        res.true_deg     = wvac_pkg::ANGLE_W'(turn);
        return res;
    endfunction

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        angle_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
                report_mismatch("unexpected result, apparent_angle", int'(apparent_angle), -1);
            else
            begin
                want = expected_angles.pop_front();
                if (apparent_angle !== want.apparent_deg)
                    report_mismatch("apparent_angle", int'(apparent_angle),
                                    int'(want.apparent_deg));
                if (true_angle !== want.true_deg)
                    report_mismatch("true_angle", int'(true_angle), int'(want.true_deg));
            end
        end
    end

    // receiver backpressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic op, input logic [EBITS-1:0] raw,
                             input logic [wvac_pkg::SAIL_W-1:0] sail,
                             input logic [wvac_pkg::HEADING_W-1:0] hdg);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        raw_angle     <= raw;
        sail_position <= sail;
        heading       <= hdg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_angles.push_back(predict_angles(op, raw, sail, hdg));
    endtask

    // drop valid and hold until every transaction has come back
    task automatic wait_for_results;
        in_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_calibration(input int offset, input int q, input int h, input int tq);
        cfg_we    <= 1'b1;
        cfg_index <= wvac_pkg::CFG_OFFSET;
        cfg_data  <= (EBITS + 1)'(offset);
        @(posedge clk);
        // the spare top bit of the breakpoint writes is don't-care
        cfg_index <= wvac_pkg::CFG_QUARTER;
        cfg_data  <= {1'($urandom), EBITS'(q)};
        @(posedge clk);
        cfg_index <= wvac_pkg::CFG_HALF;
        cfg_data  <= {1'($urandom), EBITS'(h)};
        @(posedge clk);
        cfg_index <= wvac_pkg::CFG_THREE_QUARTER;
        cfg_data  <= {1'($urandom), EBITS'(tq)};
        @(posedge clk);
        cfg_we <= 1'b0;
        model_offset        = offset;
        model_quarter       = q & ENC_MAX;
        model_half          = h & ENC_MAX;
        model_three_quarter = tq & ENC_MAX;
    endtask

    task automatic pick_calibration;
        int offset;
        int pts[3];
        int tmp;
        int shape;
        case ($urandom_range(0, 7))
            0:       offset = -4096;
            1:       offset = 4095;
            2, 3:    offset = int'($urandom_range(0, 8191)) - 4096;
            default: offset = int'($urandom_range(0, 400)) - 200;
        endcase
        for (int i = 0; i < 3; i++)
            pts[i] = int'($urandom_range(0, ENC_MAX));
        shape = int'($urandom_range(0, 5));
        if (shape == 1)
        begin
            pts[1] = pts[0];
            pts[2] = pts[0];
        end
        else if (shape == 2)
            pts[2] = ENC_MAX;
        // out-of-order breakpoints are kept as drawn for one shape
        if (shape != 0)
        begin
            for (int pass = 0; pass < 2; pass++)
                for (int i = 0; i < 2; i++)
                    if (pts[i] > pts[i + 1])
                    begin
                        tmp        = pts[i];
                        pts[i]     = pts[i + 1];
                        pts[i + 1] = tmp;
                    end
        end
        apply_calibration(offset, pts[0], pts[1], pts[2]);
    endtask

    task automatic send_random_item;
        logic                           op;
        logic [EBITS-1:0]               raw;
        logic [wvac_pkg::SAIL_W-1:0]    sail;
        logic [wvac_pkg::HEADING_W-1:0] hdg;
        op = ($urandom_range(0, 9) < 7) ? OP_SAMPLE : OP_QUERY;
        case ($urandom_range(0, 15))
            0:       raw = '0;
            1:       raw = EBITS'(ENC_MAX);
            default: raw = EBITS'($urandom);
        endcase
        sail = ($urandom_range(0, 9) == 0) ? wvac_pkg::SAIL_W'($urandom_range(181, 255))
                                           : wvac_pkg::SAIL_W'($urandom_range(0, 180));
        hdg  = ($urandom_range(0, 9) == 0) ? wvac_pkg::HEADING_W'($urandom_range(361, 511))
                                           : wvac_pkg::HEADING_W'($urandom_range(0, 360));
        send_item(op, raw, sail, hdg);
    endtask

    // reset calibration, stored angle still zero, heading extremes
    task automatic test_reset_state;
        send_item(OP_QUERY, 12'd0, 8'd0, 9'd0);
        send_item(OP_QUERY, 12'hfff, 8'hff, 9'd511);
        send_item(OP_SAMPLE, 12'd0, 8'd90, 9'd360);
        send_item(OP_SAMPLE, 12'hfff, 8'd180, 9'd0);
        send_item(OP_SAMPLE, 12'd2048, 8'd0, 9'd200);
        send_item(OP_SAMPLE, 12'd1023, 8'd255, 9'd359);
        send_item(OP_QUERY, 12'd77, 8'd12, 9'd361);
        wait_for_results;
    endtask

    // offset sums that wrap once and the one that has to clamp
    task automatic test_offset_extremes;
        apply_calibration(-4096, 1024, 2048, 3072);
        send_item(OP_SAMPLE, 12'd0, 8'd45, 9'd90);
        send_item(OP_SAMPLE, 12'hfff, 8'd90, 9'd270);
        send_item(OP_SAMPLE, 12'd1, 8'd181, 9'd10);
        wait_for_results;
        apply_calibration(4095, 1024, 2048, 3072);
        send_item(OP_SAMPLE, 12'hfff, 8'd180, 9'd180);
        send_item(OP_SAMPLE, 12'd1, 8'd0, 9'd300);
        send_item(OP_SAMPLE, 12'd0, 8'd100, 9'd45);
        wait_for_results;
    endtask

    // zero-width top segment and breakpoints out of order
    task automatic test_segment_edges;
        apply_calibration(0, 0, 0, 4095);
        send_item(OP_SAMPLE, 12'hfff, 8'd90, 9'd0);
        send_item(OP_SAMPLE, 12'd0, 8'd90, 9'd100);
        send_item(OP_SAMPLE, 12'd100, 8'd200, 9'd511);
        wait_for_results;
        apply_calibration(0, 3000, 1000, 2000);
        send_item(OP_SAMPLE, 12'd3500, 8'd90, 9'd20);
        send_item(OP_SAMPLE, 12'd1500, 8'd30, 9'd40);
        send_item(OP_SAMPLE, 12'd500, 8'd150, 9'd60);
        send_item(OP_QUERY, 12'd0, 8'd0, 9'd360);
        wait_for_results;
    endtask

    task automatic test_random_calibrations;
        for (int phase = 0; phase < 6; phase++)
        begin
            pick_calibration();
            for (int n = 0; n < 95; n++)
            begin
                // sender holds off until the block has drained
                if (n == 50)
                    wait_for_results;
                send_random_item();
            end
            wait_for_results;
        end
    endtask

    task automatic test_extreme_calibrations;
        apply_calibration(-4096, 0, 0, 0);
        repeat (40) send_random_item();
        wait_for_results;
        apply_calibration(4095, 4095, 4095, 4095);
        repeat (40) send_random_item();
        wait_for_results;
    endtask

    task automatic test_back_to_back;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        apply_calibration(int'($urandom_range(0, 200)) - 100, 1000, 2100, 3000);
        repeat (110) send_random_item();
        wait_for_results;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = wvac_pkg::CFG_OFFSET;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_QUERY;
        raw_angle     = '0;
        sail_position = '0;
        heading       = '0;
        error_count   = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        model_offset        = 0;
        model_quarter       = 1024;
        model_half          = 2048;
        model_three_quarter = 3072;
        model_stored        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_offset_extremes();
        test_segment_edges();
        test_random_calibrations();
        test_extreme_calibrations();
        test_back_to_back();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
